// ===== rtl/sensor_reading_line_parser_defines.svh =====
// ----------------------------------------------------------------------------
// sensor reading line parser assertion macros
// shared property wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef SENSOR_READING_LINE_PARSER_DEFINES_SVH
`define SENSOR_READING_LINE_PARSER_DEFINES_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define SLP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expression must never be true outside reset
`define SLP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SLP_ASSERT(lbl, clk, rst_n, prop, msg)
`define SLP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== rtl/slp_pkg.sv =====
// ----------------------------------------------------------------------------
// slp_pkg
// types and constants shared by the sensor reading line parser
// ----------------------------------------------------------------------------
package slp_pkg;

    localparam int CHANNEL_MAX    = 8;
    localparam int CONTROLLER_MAX = 7;
    localparam int Q_DEPTH        = 4;

    localparam logic [7:0] TAG_RESET = 8'd84;

    localparam logic [15:0] TEMP_LOW_MAG  = 16'd27300;
    localparam logic [15:0] TEMP_HIGH_MAG = 16'd30000;
    localparam logic signed [15:0] TEMP_LOW     = -16'sd27300;
    localparam logic signed [15:0] TEMP_HIGH    = 16'sd30000;
    localparam logic signed [15:0] TEMP_INVALID = -16'sd30000;
    localparam logic [15:0] ACCUM_SAT = 16'hFFFF;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    // configuration register indexes
    localparam logic REG_TAG_CHAR  = 1'b0;
    localparam logic REG_EXP_CTRL  = 1'b1;

    typedef enum logic [2:0] {
        PH_START,
        PH_SKIP,
        PH_REJECT,
        PH_CTRL,
        PH_CHAN,
        PH_TEMP,
        PH_TAIL
    } t_phase;

    typedef enum logic [1:0] {
        ST_VALID,
        ST_BAD_TEMP,
        ST_REJECT
    } t_status;

    // classified character, as carried through the queue
    typedef struct packed {
        logic       is_end;
        logic       is_tag;
        logic       is_blank;
        logic       is_plus;
        logic       is_minus;
        logic       is_digit;
        logic       is_under;
        logic       is_equal;
        logic [3:0] digit;
    } t_char_info;

endpackage

// ===== rtl/slp_front.sv =====
// ----------------------------------------------------------------------------
// slp_front
// character classifier ahead of the queue
// ----------------------------------------------------------------------------
module slp_front
    import slp_pkg::*;
(
    input  logic [7:0]  i_char,
    input  logic [7:0]  i_tag_char,
    output t_char_info  o_info
);

    always_comb begin
        o_info.is_end   = (i_char == CH_LF) || (i_char == CH_NUL);
        o_info.is_tag   = (i_char == i_tag_char);
        o_info.is_blank = (i_char == CH_SPACE) || (i_char == CH_TAB) || (i_char == CH_VT)
                       || (i_char == CH_FF) || (i_char == CH_CR);
        o_info.is_plus  = (i_char == CH_PLUS);
        o_info.is_minus = (i_char == CH_MINUS);
        o_info.is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
        o_info.is_under = (i_char == CH_UNDER);
        o_info.is_equal = (i_char == CH_EQUAL);
        // ascii digits sit at 0x30..0x39, low nibble is the value
        o_info.digit    = i_char[3:0];
    end

endmodule

// ===== rtl/slp_queue.sv =====
// ----------------------------------------------------------------------------
// slp_queue
// short fifo of classified characters between front and back
// ----------------------------------------------------------------------------
module slp_queue
    import slp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_char_info  i_data,
    output logic        o_full,
    output logic        o_valid,
    output t_char_info  o_data,
    input  logic        i_pop
);

    localparam int AW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_char_info      r_mem [Q_DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/slp_back.sv =====
// ----------------------------------------------------------------------------
// slp_back
// line parsing state machine and registered result slot
// ----------------------------------------------------------------------------
`include "sensor_reading_line_parser_defines.svh"

module slp_back
    import slp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [2:0]         i_exp_ctrl,
    input  logic               i_q_valid,
    input  t_char_info         i_info,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic [3:0]         o_channel,
    output logic               o_pair_index,
    output logic signed [15:0] o_temp_centi
);

    localparam logic [15:0] CHAN_LIMIT = 16'(CHANNEL_MAX * 10 + 9);
    localparam logic [3:0]  CTRL_LIMIT = 4'(CONTROLLER_MAX);

    t_phase       r_phase, n_phase;
    logic [15:0]  r_accum, n_accum;
    logic         r_neg, n_neg;
    logic         r_has, n_has;
    logic         r_sign, n_sign;
    logic [3:0]   r_saved_chan, n_saved_chan;
    logic         r_saved_pair, n_saved_pair;
    logic [3:0]   r_prev_lo, n_prev_lo;
    logic [3:0]   r_units, n_units;

    logic               r_out_valid;
    t_status            r_status;
    logic [3:0]         r_channel;
    logic               r_pair;
    logic signed [15:0] r_temp;

    logic [19:0]  times_ten;
    logic         ctrl_ok, chan_ok, temp_ok;
    logic         emit, out_free;
    t_status      res_status;
    logic [3:0]   res_chan;
    logic         res_pair;
    logic [15:0]  res_temp;

    assign times_ten = {r_accum, 3'b000} + {3'b000, r_accum, 1'b0} + {16'd0, i_info.digit};

    assign ctrl_ok = r_has && (r_accum == {13'd0, i_exp_ctrl})
                  && (!r_neg || (i_exp_ctrl == 3'd0))
                  && ({1'b0, i_exp_ctrl} <= CTRL_LIMIT);

    // tens is the accumulator before the last digit, units the last digit
    assign chan_ok = r_has && (!r_neg || (r_accum == 16'd0))
                  && (r_accum <= CHAN_LIMIT) && (r_units <= 4'd1);

    assign temp_ok = r_has && (r_accum != ACCUM_SAT)
                  && (r_neg ? (r_accum <= TEMP_LOW_MAG) : (r_accum <= TEMP_HIGH_MAG));

    always_comb begin
        emit       = 1'b0;
        res_status = ST_REJECT;
        res_chan   = 4'd0;
        res_pair   = 1'b0;
        res_temp   = TEMP_INVALID;
        if (i_info.is_end) begin
            unique case (r_phase)
                PH_TEMP, PH_TAIL: begin
                    emit     = 1'b1;
                    res_chan = r_saved_chan;
                    res_pair = r_saved_pair;
                    if (temp_ok) begin
                        res_status = ST_VALID;
                        res_temp   = r_neg ? (16'd0 - r_accum) : r_accum;
                    end else begin
                        res_status = ST_BAD_TEMP;
                    end
                end
                PH_REJECT, PH_CTRL, PH_CHAN: begin
                    emit = 1'b1;
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = i_q_valid && (!emit || out_free);

    always_comb begin
        n_phase      = r_phase;
        n_accum      = r_accum;
        n_neg        = r_neg;
        n_has        = r_has;
        n_sign       = r_sign;
        n_saved_chan = r_saved_chan;
        n_saved_pair = r_saved_pair;
        n_prev_lo    = r_prev_lo;
        n_units      = r_units;
        if (i_info.is_end) begin
            n_phase      = PH_START;
            n_accum      = 16'd0;
            n_neg        = 1'b0;
            n_has        = 1'b0;
            n_sign       = 1'b0;
            n_saved_chan = 4'd0;
            n_saved_pair = 1'b0;
        end else begin
            unique case (r_phase)
                PH_START: begin
                    n_accum = 16'd0;
                    n_neg   = 1'b0;
                    n_has   = 1'b0;
                    n_sign  = 1'b0;
                    n_phase = i_info.is_tag ? PH_CTRL : PH_SKIP;
                end
                PH_CTRL, PH_CHAN, PH_TEMP: begin
                    if (!r_has && !r_sign && i_info.is_blank) begin
                        n_phase = r_phase;
                    end else if (!r_has && !r_sign && (i_info.is_plus || i_info.is_minus)) begin
                        n_sign = 1'b1;
                        n_neg  = i_info.is_minus;
                    end else if (i_info.is_digit) begin
                        n_accum   = (times_ten[19:16] != 4'd0) ? ACCUM_SAT : times_ten[15:0];
                        n_has     = 1'b1;
                        n_prev_lo = r_accum[3:0];
                        n_units   = i_info.digit;
                    end else if (r_phase == PH_CTRL) begin
                        if (ctrl_ok && i_info.is_under) begin
                            n_phase = PH_CHAN;
                            n_accum = 16'd0;
                            n_neg   = 1'b0;
                            n_has   = 1'b0;
                            n_sign  = 1'b0;
                        end else begin
                            n_phase = PH_REJECT;
                        end
                    end else if (r_phase == PH_CHAN) begin
                        if (chan_ok && i_info.is_equal) begin
                            n_saved_chan = r_prev_lo;
                            n_saved_pair = r_units[0];
                            n_phase      = PH_TEMP;
                            n_accum      = 16'd0;
                            n_neg        = 1'b0;
                            n_has        = 1'b0;
                            n_sign       = 1'b0;
                        end else begin
                            n_phase = PH_REJECT;
                        end
                    end else begin
                        n_phase = PH_TAIL;
                    end
                end
                PH_SKIP, PH_REJECT, PH_TAIL: begin
                    n_phase = r_phase;
                end
                default: begin
                    n_phase = PH_SKIP;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_accum      <= 16'd0;
            r_neg        <= 1'b0;
            r_has        <= 1'b0;
            r_sign       <= 1'b0;
            r_saved_chan <= 4'd0;
            r_saved_pair <= 1'b0;
            r_prev_lo    <= 4'd0;
            r_units      <= 4'd0;
        end else if (o_pop) begin
            r_phase      <= n_phase;
            r_accum      <= n_accum;
            r_neg        <= n_neg;
            r_has        <= n_has;
            r_sign       <= n_sign;
            r_saved_chan <= n_saved_chan;
            r_saved_pair <= n_saved_pair;
            r_prev_lo    <= n_prev_lo;
            r_units      <= n_units;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_status  <= res_status;
            r_channel <= res_chan;
            r_pair    <= res_pair;
            r_temp    <= res_temp;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_channel    = r_channel;
    assign o_pair_index = r_pair;
    assign o_temp_centi = r_temp;

    `SLP_ASSERT(a_end_restarts, i_clk, i_rst_n, (o_pop && i_info.is_end) |=> (r_phase == PH_START), "line end did not restart parsing")
    `SLP_ASSERT_NEVER(a_chan_range, i_clk, i_rst_n, r_saved_chan > 4'(CHANNEL_MAX), "saved channel beyond limit")
    `SLP_ASSERT(a_valid_temp, i_clk, i_rst_n, (r_out_valid && (r_status == ST_VALID)) |-> ((r_temp >= TEMP_LOW) && (r_temp <= TEMP_HIGH)), "valid reading out of range")
    `SLP_ASSERT(a_reject_form, i_clk, i_rst_n, (r_out_valid && (r_status != ST_VALID)) |-> (r_temp == TEMP_INVALID), "bad result without invalid marker")
    `SLP_ASSERT(a_no_overwrite, i_clk, i_rst_n, (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_temp) && $stable(r_status)), "pending result overwritten")

endmodule

// ===== rtl/sensor_reading_line_parser.sv =====
// ----------------------------------------------------------------------------
// sensor_reading_line_parser
// frames tagged text lines and parses controller, sensor and temperature
// ----------------------------------------------------------------------------
// usage
//   input channel: one ascii character per transaction on i_char_in, taken
//   when i_valid and o_ready are both high. a line ends with 0x0a or 0x00.
//   output channel: one result per tagged line (status, channel, pair index,
//   temperature in hundredths of a degree), offered on o_valid until i_ready.
//   configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
//   (0 tag character, 1 expected controller) at the clock edge; write only
//   while idle.
//   throughput: one character per cycle while o_ready is high, with one parse
//   step (one multiply-by-ten accumulate) in the back end for each character.
//   result path: a line end is written into the queue, popped by the back end,
//   and its result registered in the output slot.
//   stall: while a result waits, the back end keeps parsing characters that
//   give no result; the four-entry queue absorbs the rest, then o_ready drops.
//   reset: synchronous active-low, clears queue, parser state and the output
//   slot; tag character resets to 'T', expected controller to 0.
// ----------------------------------------------------------------------------
module sensor_reading_line_parser
    import slp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    // character input
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_char_in,
    // result output
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic [3:0]         o_channel,
    output logic               o_pair_index,
    output logic signed [15:0] o_temp_centi
);

    // configuration registers
    logic [7:0] r_tag_char;
    logic [2:0] r_exp_ctrl;

    // front to queue to back
    t_char_info front_info;
    t_char_info q_info;
    logic       q_full;
    logic       q_valid;
    logic       q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_char <= TAG_RESET;
            r_exp_ctrl <= 3'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TAG_CHAR: r_tag_char <= i_cfg_data;
                REG_EXP_CTRL: r_exp_ctrl <= i_cfg_data[2:0];
                default:      r_tag_char <= r_tag_char;
            endcase
        end
    end

    // queue space is the only thing that holds off the sender
    assign o_ready = !q_full;

    // classify characters on arrival; tag compare happens here, so the user must
    // change the tag register only while the pipe is drained; not enforced here
    slp_front u_front (
        .i_char     (i_char_in),
        .i_tag_char (r_tag_char),
        .o_info     (front_info)
    );

    // decouples acceptance from result back-pressure
    slp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_data  (front_info),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_info),
        .i_pop   (q_pop)
    );

    // line state machine with the registered result slot
    slp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_exp_ctrl   (r_exp_ctrl),
        .i_q_valid    (q_valid),
        .i_info       (q_info),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_channel    (o_channel),
        .o_pair_index (o_pair_index),
        .o_temp_centi (o_temp_centi)
    );

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// character-stream checker for the sensor reading line parser: a queue-fed
// driver sends text lines, a per-character parser in the bench predicts each
// result at line end, and the monitor compares the results field by field
// ----------------------------------------------------------------------------
module tb_top;
    import slp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 12;

    // one predicted line result
    typedef struct packed {
        t_status            status;
        logic [3:0]         channel;
        logic               pair;
        logic signed [15:0] temp;
    } t_reading;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_index = REG_TAG_CHAR;
    logic [7:0]         i_cfg_data = 8'd0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [7:0]         i_char_in = 8'd0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [1:0]         o_status;
    logic [3:0]         o_channel;
    logic               o_pair_index;
    logic signed [15:0] o_temp_centi;

    sensor_reading_line_parser u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_char_in    (i_char_in),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_channel    (o_channel),
        .o_pair_index (o_pair_index),
        .o_temp_centi (o_temp_centi)
    );

    // characters waiting to be sent and readings waiting to come out
    logic [7:0] pending_chars [$];
    t_reading   pending_readings [$];

    int  cycle_count = 0;
    int  mismatch_count = 0;
    int  pushed_chars = 0;
    // long window with no idling on either side
    wire quiet = (cycle_count >= 600) && (cycle_count < 1400);

    logic [7:0] blank_set [0:4] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};

    // ------------------------------------------------------------------------
    // line parser model: register copies and per-line state
    // ------------------------------------------------------------------------
    logic [7:0]  tag_cfg = TAG_RESET;
    logic [2:0]  ctrl_cfg = 3'd0;
    t_phase      line_phase = PH_START;
    logic [15:0] num_mag = 16'd0;
    logic        num_neg = 1'b0;
    logic        num_digits = 1'b0;
    logic        num_signed = 1'b0;
    logic [3:0]  chan_hold = 4'd0;
    logic        pair_hold = 1'b0;

    task automatic clear_num();
        num_mag = 16'd0;
        num_neg = 1'b0;
        num_digits = 1'b0;
        num_signed = 1'b0;
    endtask

    task automatic push_reading(t_status s, logic [3:0] ch, logic pr,
                                logic signed [15:0] t);
        t_reading r;
        r.status = s;
        r.channel = ch;
        r.pair = pr;
        r.temp = t;
        pending_readings.push_back(r);
    endtask

    // line end after the '=' was reached
    task automatic close_temp();
        if (!num_digits || num_mag == ACCUM_SAT) begin
            // missing or saturated temperature
            push_reading(ST_BAD_TEMP, chan_hold, pair_hold, TEMP_INVALID);
        end else if (num_neg ? (num_mag > TEMP_LOW_MAG) : (num_mag > TEMP_HIGH_MAG)) begin
            push_reading(ST_BAD_TEMP, chan_hold, pair_hold, TEMP_INVALID);
        end else begin
            push_reading(ST_VALID, chan_hold, pair_hold,
                         num_neg ? -$signed(num_mag) : $signed(num_mag));
        end
    endtask

    // the current number was ended by a non-number character c
    task automatic end_number(logic [7:0] c);
        logic        ok;
        logic [15:0] tens;
        logic [15:0] units;
        case (line_phase)
            PH_CTRL: begin
                ok = num_digits && num_mag != ACCUM_SAT &&
                     (num_neg ? (num_mag == 16'd0 && ctrl_cfg == 3'd0)
                              : (num_mag == {13'd0, ctrl_cfg}));
                if (ok && c == CH_UNDER && ctrl_cfg <= CONTROLLER_MAX) begin
                    line_phase = PH_CHAN;
                    clear_num();
                end else begin
                    line_phase = PH_REJECT;
                end
            end
            PH_CHAN: begin
                ok = num_digits && num_mag != ACCUM_SAT;
                // a minus sign on the sensor number survives only when the value is zero
                if (num_neg && num_mag != 16'd0)
                    ok = 1'b0;
                tens = num_mag / 16'd10;
                units = num_mag % 16'd10;
                if (tens > CHANNEL_MAX || units > 16'd1)
                    ok = 1'b0;
                if (ok && c == CH_EQUAL) begin
                    chan_hold = tens[3:0];
                    pair_hold = units[0];
                    line_phase = PH_TEMP;
                    clear_num();
                end else begin
                    line_phase = PH_REJECT;
                end
            end
            default: begin
                // anything after the temperature is ignored
                line_phase = PH_TAIL;
            end
        endcase
    endtask

    // advance the model by one accepted character
    task automatic parse_char(logic [7:0] c);
        logic [19:0] grown;
        if (c == CH_LF || c == CH_NUL) begin
            if (line_phase == PH_TEMP || line_phase == PH_TAIL)
                close_temp();
            else if (line_phase == PH_REJECT || line_phase == PH_CTRL ||
                     line_phase == PH_CHAN)
                push_reading(ST_REJECT, 4'd0, 1'b0, TEMP_INVALID);
            // untagged and empty lines give nothing
            line_phase = PH_START;
            clear_num();
            chan_hold = 4'd0;
            pair_hold = 1'b0;
        end else begin
            case (line_phase)
                PH_START: begin
                    clear_num();
                    line_phase = (c == tag_cfg) ? PH_CTRL : PH_SKIP;
                end
                PH_CTRL, PH_CHAN, PH_TEMP: begin
                    if (!num_digits && !num_signed &&
                        (c == CH_SPACE || c == CH_TAB || c == CH_VT ||
                         c == CH_FF || c == CH_CR)) begin
                        // leading blank, skipped
                    end else if (!num_digits && !num_signed &&
                                 (c == CH_PLUS || c == CH_MINUS)) begin
                        num_signed = 1'b1;
                        num_neg = (c == CH_MINUS);
                    end else if (c >= CH_ZERO && c <= CH_NINE) begin
                        grown = num_mag * 20'd10 + (c - CH_ZERO);
                        num_mag = (grown > ACCUM_SAT) ? ACCUM_SAT : grown[15:0];
                        num_digits = 1'b1;
                    end else begin
                        end_number(c);
                    end
                end
                default: begin
                    // skipped, rejected or tail: wait for line end
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_char(logic [7:0] c);
        pending_chars.push_back(c);
        pushed_chars++;
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
    endtask

    // one number: optional blanks, sign, leading zero; digits when with_digits
    task automatic add_field(bit neg, int unsigned mag, bit with_digits);
        int n_blank;
        n_blank = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n_blank)
            add_char(blank_set[$urandom_range(4)]);
        if (neg)
            add_char(CH_MINUS);
        else if ($urandom_range(5) == 0)
            add_char(CH_PLUS);
        if (with_digits) begin
            if ($urandom_range(7) == 0)
                add_char(CH_ZERO);
            add_text($sformatf("%0d", mag));
        end
    endtask

    // random byte that does not end a line
    function automatic logic [7:0] mid_line_byte();
        return 8'($urandom_range(11, 255));
    endfunction

    // one random line; counted is low for untagged noise the block ignores
    task automatic add_random_line(output bit counted);
        int          kind;
        int          tk;
        int          t;
        int unsigned mag;
        int unsigned ctrl_v;
        int unsigned chan_v;
        bit          neg;
        logic [7:0]  c;
        string       alphabet;
        alphabet = "0123456789_=+- .";
        counted = 1'b1;
        kind = $urandom_range(99);
        if (kind < 72) begin
            // well-formed line with random content
            add_char(tag_cfg);
            ctrl_v = ($urandom_range(9) == 0) ? $urandom_range(9) : ctrl_cfg;
            add_field(ctrl_v == 0 && $urandom_range(7) == 0, ctrl_v, 1'b1);
            add_char(CH_UNDER);
            if ($urandom_range(6) == 0)
                chan_v = $urandom_range(199);
            else
                chan_v = $urandom_range(CHANNEL_MAX) * 10 + $urandom_range(1);
            add_field(1'b0, chan_v, 1'b1);
            add_char(CH_EQUAL);
            tk = $urandom_range(99);
            if (tk < 90) begin
                if (tk < 70) begin
                    t = int'($urandom_range(57300)) - 27300;
                end else if (tk < 78) begin
                    case ($urandom_range(4))
                        0: t = -27300;
                        1: t = -27301;
                        2: t = 30000;
                        3: t = 30001;
                        default: t = 0;
                    endcase
                end else begin
                    t = int'($urandom_range(199998)) - 99999;
                end
                neg = (t < 0);
                mag = neg ? -t : t;
                add_field(neg, mag, 1'b1);
            end else if (tk < 95) begin
                // saturating magnitude
                add_field($urandom_range(1), $urandom_range(65535, 9999999), 1'b1);
            end else begin
                // temperature with no digits
                add_field($urandom_range(1), 0, 1'b0);
            end
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 4))
                    add_char(mid_line_byte());
        end else if (kind < 84) begin
            // tagged line of scrambled number characters
            add_char(tag_cfg);
            repeat ($urandom_range(1, 12)) begin
                if ($urandom_range(7) == 0)
                    add_char(mid_line_byte());
                else
                    add_char(alphabet[$urandom_range(alphabet.len() - 1)]);
            end
        end else if (kind < 92) begin
            // untagged noise or an empty line
            counted = 1'b0;
            if ($urandom_range(4) != 0) begin
                c = 8'($urandom_range(1, 255));
                if (c == tag_cfg || c == CH_LF)
                    c = tag_cfg ^ 8'h80;
                add_char(c);
                repeat ($urandom_range(10))
                    add_char(mid_line_byte());
            end
        end else begin
            // line cut short before the temperature
            add_char(tag_cfg);
            add_field(1'b0, ctrl_cfg, 1'b1);
            if ($urandom_range(1)) begin
                add_char(CH_UNDER);
                if ($urandom_range(1))
                    add_field(1'b0, $urandom_range(CHANNEL_MAX) * 10 + $urandom_range(1),
                              1'b1);
            end
        end
        add_char(($urandom_range(4) == 0) ? CH_NUL : CH_LF);
    endtask

    // all characters sent, all readings seen, back end settled
    task automatic wait_drained();
        while (pending_chars.size() != 0 || i_valid || pending_readings.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_regs(logic [7:0] tag, logic [2:0] ctrl);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_TAG_CHAR;
        i_cfg_data <= tag;
        tag_cfg = tag;
        @(posedge i_clk);
        i_cfg_index <= REG_EXP_CTRL;
        i_cfg_data <= {5'd0, ctrl};
        ctrl_cfg = ctrl;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // new register setting, then random lines until about n characters
    task automatic run_phase(logic [7:0] tag, logic [2:0] ctrl, int n);
        int  counted_chars;
        int  mark;
        bit  counted;
        wait_drained();
        write_regs(tag, ctrl);
        counted_chars = 0;
        while (counted_chars < n) begin
            mark = pushed_chars;
            add_random_line(counted);
            if (counted)
                counted_chars += pushed_chars - mark;
        end
    endtask

    // ------------------------------------------------------------------------
    // clock, cycle limit
    // ------------------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // driver: one character per transaction, random gaps between them
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                parse_char(i_char_in);
            // new character only when the slot is empty or just taken
            if (!i_valid || o_ready) begin
                if (pending_chars.size() != 0 && (quiet || $urandom_range(99) >= 6)) begin
                    i_valid <= 1'b1;
                    i_char_in <= pending_chars.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random backpressure, compare each result with the oldest reading
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch
        t_reading want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= quiet || ($urandom_range(99) >= 6);
            if (o_valid && i_ready) begin
                if (pending_readings.size() == 0) begin
                    $error("unexpected result: status %0d channel %0d pair %0d temp %0d",
                           o_status, o_channel, o_pair_index, o_temp_centi);
                    mismatch_count++;
                end else begin
                    want = pending_readings.pop_front();
                    if (o_status != want.status) begin
                        $error("status expected %0d actual %0d", want.status, o_status);
                        mismatch_count++;
                    end
                    if (o_channel != want.channel) begin
                        $error("channel expected %0d actual %0d", want.channel, o_channel);
                        mismatch_count++;
                    end
                    if (o_pair_index != want.pair) begin
                        $error("pair_index expected %0d actual %0d", want.pair,
                               o_pair_index);
                        mismatch_count++;
                    end
                    if (o_temp_centi != want.temp) begin
                        $error("temp_centi expected %0d actual %0d", want.temp,
                               o_temp_centi);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed lines under the reset setting: tag 'T', controller 0
        add_char(CH_LF);                         // empty line
        add_text("T0_81=30000\n");               // top channel, top temperature
        add_text("T");                           // blanks and plus sign
        add_char(CH_SPACE);
        add_char(CH_TAB);
        add_text("+0_");
        add_char(CH_VT);
        add_char(CH_FF);
        add_char(CH_CR);
        add_text("00=-27300");
        add_char(CH_NUL);
        add_text("T-0_10=-0\n");                 // negative zero
        add_text("T0_11=30001\n");               // just above range
        add_text("T0_1=-27301\n");               // just below range
        add_text("T0_1=\n");                     // missing temperature
        add_text("T0_1=65535\n");                // saturates exactly
        add_text("T0_1=99999999\n");             // overflow
        add_text("T0_91=5\n");                   // channel above limit
        add_text("T0_12=5\n");                   // pair digit too big
        add_text("T1_0=5\n");                    // wrong controller
        add_text("T0_1\n");                      // ends before '='
        add_text("T\n");
        add_text("X0_1=5\n");                    // untagged
        add_text("T0_1=123abc");                 // ignored tail, high byte
        add_char(8'hFF);
        add_char(CH_LF);
        add_text("T0-1=5\n");                    // wrong separator
        add_text("T0_1=- 5\n");                  // sign then blank
        add_text("T++0_1=5\n");                  // double sign
        add_text("T0_-1=5\n");                   // negative sensor
        add_text("T0_-0=1\n");

        // random lines over several register settings
        run_phase(8'hFF, 3'd7, 350);
        run_phase(8'h23, 3'd3, 350);
        run_phase(8'h00, 3'd0, 40);              // every line ends at once
        run_phase(8'h35, 3'd0, 300);             // tag is a digit
        run_phase(TAG_RESET, 3'd7, 350);
        run_phase(TAG_RESET, 3'd0, 300);
        wait_drained();

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sensor_reading_line_parser.f =====
+incdir+rtl
rtl/slp_pkg.sv
rtl/slp_front.sv
rtl/slp_queue.sv
rtl/slp_back.sv
rtl/sensor_reading_line_parser.sv
test/tb_top.sv
